>>> rtl/core/sle_pkg.sv
// Shared types and codes for the sequential list engine.
`timescale 1ns / 1ps
package sle_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int HIT_W          = $clog2(MAX_RESULTS + 1);

	localparam int OP_W     = 3;
	localparam int KEY_W    = 31;
	localparam int TAG_W    = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 3;
	localparam int FPOS_W   = 4;
	localparam int ECNT_W   = 5;

	localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
	localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd3;
	localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd4;
	localparam logic [OP_W-1:0] OP_REM_POS  = 3'd5;
	localparam logic [OP_W-1:0] OP_SEARCH   = 3'd6;

	localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STS_BADPOS   = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;

	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CELL_HOLD   = 3'd0;
	localparam logic [CMD_W-1:0] CELL_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CELL_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CELL_SEARCH = 3'd3;
	localparam logic [CMD_W-1:0] CELL_ROTATE = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] record_key;
		logic [TAG_W-1:0] name_tag;
		logic [POS_W-1:0] position;
	} sle_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FPOS_W-1:0]   found_position;
		logic [KEY_W-1:0]    out_key;
		logic [TAG_W-1:0]    out_name_tag;
		logic [ECNT_W-1:0]   entry_count;
		logic                last;
	} sle_rsp_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} sle_ctrl_t;

	// What one cell shows its neighbors
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             match;
	} sle_link_t;

endpackage

>>> rtl/core/sle_cell.sv
// One list slot: holds a record and a search match bit, shifts with its neighbors.
`timescale 1ns / 1ps
module sle_cell #(
	parameter int INDEX = 0,
	parameter int CMP_W = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sle_pkg::sle_ctrl_t ctrl,
	input  logic [CMP_W-1:0]   pos,
	input  logic [CMP_W-1:0]   count,
	input  sle_pkg::sle_link_t lower,
	input  sle_pkg::sle_link_t upper,
	output sle_pkg::sle_link_t link
);
	import sle_pkg::*;

	localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;
	logic             match_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CELL_INSERT: begin
				if (IDX == pos) begin
					key_q <= ctrl.key;
					tag_q <= ctrl.tag;
				end else if (IDX > pos) begin
					key_q <= lower.key;
					tag_q <= lower.tag;
				end
			end
			CELL_REMOVE: begin
				if (IDX >= pos) begin
					key_q <= upper.key;
					tag_q <= upper.tag;
				end
			end
			CELL_ROTATE: begin
				key_q <= upper.key;
				tag_q <= upper.tag;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			case (ctrl.cmd)
				CELL_SEARCH: match_q <= (key_q == ctrl.key) && (IDX < count);
				CELL_ROTATE: match_q <= upper.match;
				default:     match_q <= match_q;
			endcase
		end
	end

	assign link.key   = key_q;
	assign link.tag   = tag_q;
	assign link.match = match_q;

endmodule

>>> rtl/core/sequential_list_engine.sv
// Top level of the sequential list engine: controller, output register and ring of cells.
`timescale 1ns / 1ps
// Ordered list of up to LIST_DEPTH records kept in a ring of cells, position 0 in
// the first cell. Inserts and removals shift every later cell by one place in the
// cycle the request transfers; the result is shown the next cycle and a new request
// is taken as soon as the output register is free, so these run at one request per
// cycle when the consumer keeps up. A search compares all cells at once in the
// transfer cycle, then turns the ring LIST_DEPTH times so that each record passes
// the first cell in position order, giving at most one result per step; the ring
// holds while the consumer stalls on a match. A search that matches nothing reports
// not-found once and leaves the ring as it is. At most 16 matches are reported.
module sequential_list_engine #(
	parameter int LIST_DEPTH = sle_pkg::LIST_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sle_pkg::sle_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sle_pkg::sle_rsp_t rsp
);
	import sle_pkg::*;

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic             state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] step_q, step_d;
	logic [HIT_W-1:0] hit_q, hit_d;
	logic             rsp_valid_q;
	sle_rsp_t         rsp_q;

	sle_ctrl_t        ctrl;
	logic [CMP_W-1:0] cell_pos;
	logic [CMP_W-1:0] cnt_c;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] ins_pos;
	logic [CMP_W-1:0] rem_pos;
	logic [CMP_W-1:0] step_ext;
	logic             slot_free;
	logic             accept;
	logic             emit;
	sle_rsp_t         res;
	logic             full;
	logic             empty;
	logic             any_match;
	logic             more_match;
	logic             need_emit;

	sle_link_t           cell_link  [LIST_DEPTH];
	sle_link_t           upper_link [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] match_vec;

	genvar gi;
	generate
		for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
			localparam int LO = (gi + LIST_DEPTH - 1) % LIST_DEPTH;
			localparam int UP = (gi + 1) % LIST_DEPTH;

			// The top cell wraps to the head; its match bit drops out of the ring
			if (gi == LIST_DEPTH - 1) begin : g_top
				assign upper_link[gi].key   = cell_link[UP].key;
				assign upper_link[gi].tag   = cell_link[UP].tag;
				assign upper_link[gi].match = 1'b0;
			end else begin : g_mid
				assign upper_link[gi] = cell_link[UP];
			end

			assign match_vec[gi] = cell_link[gi].match;

			sle_cell #(
				.INDEX (gi),
				.CMP_W (CMP_W)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.pos    (cell_pos),
				.count  (cnt_c),
				.lower  (cell_link[LO]),
				.upper  (upper_link[gi]),
				.link   (cell_link[gi])
			);
		end
	endgenerate

	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == S_IDLE) && slot_free;
	assign accept     = req_valid && req_ready;
	assign cnt_c      = CMP_W'(count_q);
	assign pos_c      = CMP_W'(req.position);
	assign step_ext   = CMP_W'(step_q);
	assign full       = (cnt_c == CMP_W'(LIST_DEPTH));
	assign empty      = (count_q == '0);
	assign any_match  = |match_vec;
	assign more_match = |match_vec[LIST_DEPTH-1:1];
	assign need_emit  = match_vec[0] && (hit_q < HIT_W'(MAX_RESULTS));

	always_comb begin
		ins_pos = pos_c;
		rem_pos = pos_c;
		case (req.operation)
			OP_INS_HEAD: ins_pos = '0;
			OP_INS_TAIL: ins_pos = cnt_c;
			OP_REM_HEAD: rem_pos = '0;
			OP_REM_TAIL: rem_pos = cnt_c - CMP_W'(1);
			default: begin
			end
		endcase
	end

	always_comb begin
		ctrl.cmd = CELL_HOLD;
		ctrl.key = req.record_key;
		ctrl.tag = req.name_tag;
		cell_pos = '0;
		state_d  = state_q;
		count_d  = count_q;
		step_d   = step_q;
		hit_d    = hit_q;
		emit     = 1'b0;

		res.status         = STS_OK;
		res.found_position = '0;
		res.out_key        = '0;
		res.out_name_tag   = '0;
		res.entry_count    = cnt_c[ECNT_W-1:0];
		res.last           = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.operation)
						OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
							emit = 1'b1;
							if (full) begin
								res.status = STS_FULL;
							end else if (ins_pos > cnt_c) begin
								res.status = STS_BADPOS;
							end else begin
								ctrl.cmd           = CELL_INSERT;
								cell_pos           = ins_pos;
								count_d            = count_q + CNT_W'(1);
								res.found_position = ins_pos[FPOS_W-1:0];
								res.entry_count    = ECNT_W'(cnt_c + CMP_W'(1));
							end
						end
						OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS: begin
							emit = 1'b1;
							if (empty) begin
								res.status = STS_EMPTY;
							end else if (rem_pos >= cnt_c) begin
								res.status = STS_BADPOS;
							end else begin
								ctrl.cmd           = CELL_REMOVE;
								cell_pos           = rem_pos;
								count_d            = count_q - CNT_W'(1);
								res.found_position = rem_pos[FPOS_W-1:0];
								res.out_key        = cell_link[rem_pos[IDX_W-1:0]].key;
								res.out_name_tag   = cell_link[rem_pos[IDX_W-1:0]].tag;
								res.entry_count    = ECNT_W'(cnt_c - CMP_W'(1));
							end
						end
						OP_SEARCH: begin
							if (empty) begin
								emit       = 1'b1;
								res.status = STS_EMPTY;
							end else begin
								ctrl.cmd = CELL_SEARCH;
								state_d  = S_SCAN;
								step_d   = '0;
								hit_d    = '0;
							end
						end
						default: begin
							emit       = 1'b1;
							res.status = STS_BADPOS;
						end
					endcase
				end
			end
			S_SCAN: begin
				if ((step_q == '0) && !any_match) begin
					// nothing matched: report once and drop the scan
					res.status = STS_NOTFOUND;
					if (slot_free) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else if (!need_emit || slot_free) begin
					// advance the ring one place; the head cell holds position step_q
					ctrl.cmd = CELL_ROTATE;
					step_d   = step_q + IDX_W'(1);
					if (need_emit) begin
						emit               = 1'b1;
						hit_d              = hit_q + HIT_W'(1);
						res.found_position = step_ext[FPOS_W-1:0];
						res.out_key        = cell_link[0].key;
						res.out_name_tag   = cell_link[0].tag;
						res.last           = (hit_q == HIT_W'(MAX_RESULTS - 1)) || !more_match;
					end
					if (step_q == IDX_W'(LIST_DEPTH - 1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			hit_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q  <= step_d;
			hit_q   <= hit_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sim/sequential_list_engine_tb.sv
// Self-checking testbench for the sequential list engine.
`timescale 1ns / 1ps
module sequential_list_engine_tb;
	import sle_pkg::*;

	localparam int DEPTH = LIST_DEPTH_DEF;
	localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam logic [TAG_W-1:0] TAG_MAX = '1;
	localparam logic [KEY_W-1:0] FILL_KEY = 31'h2AAA_5555;

	// Tracks the list contents and the responses each request must produce
	class list_scoreboard;
		logic [KEY_W-1:0] keys [DEPTH];
		logic [TAG_W-1:0] tags [DEPTH];
		int unsigned held;
		sle_rsp_t awaited_rsps [$];
		int errors;
		int checked;
		int multi_hits;
		int flag_hits [5];

		function void queue_result(logic [STATUS_W-1:0] st, int unsigned pos,
			logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, bit fin);
			sle_rsp_t r;
			r.status         = st;
			r.found_position = FPOS_W'(pos);
			r.out_key        = k;
			r.out_name_tag   = t;
			r.entry_count    = ECNT_W'(held);
			r.last           = fin;
			awaited_rsps.push_back(r);
			if (st <= STS_NOTFOUND)
				flag_hits[st]++;
		endfunction

		function void note_request(sle_req_t q);
			int unsigned at;
			int unsigned i;
			int hits;
			logic [KEY_W-1:0] k;
			logic [TAG_W-1:0] t;
			sle_rsp_t r;
			case (q.operation)
				OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
					at = (q.operation == OP_INS_HEAD) ? 0 :
						(q.operation == OP_INS_TAIL) ? held : q.position;
					// fullness wins over a bad position
					if (held >= DEPTH)
						queue_result(STS_FULL, 0, '0, '0, 1'b1);
					else if (at > held)
						queue_result(STS_BADPOS, 0, '0, '0, 1'b1);
					else begin
						for (i = held; i > at; i--) begin
							keys[i] = keys[i-1];
							tags[i] = tags[i-1];
						end
						keys[at] = q.record_key;
						tags[at] = q.name_tag;
						held++;
						queue_result(STS_OK, at, '0, '0, 1'b1);
					end
				end
				OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS: begin
					if (held == 0)
						queue_result(STS_EMPTY, 0, '0, '0, 1'b1);
					else begin
						at = (q.operation == OP_REM_HEAD) ? 0 :
							(q.operation == OP_REM_TAIL) ? held - 1 : q.position;
						if (at >= held)
							queue_result(STS_BADPOS, 0, '0, '0, 1'b1);
						else begin
							k = keys[at];
							t = tags[at];
							for (i = at; i + 1 < held; i++) begin
								keys[i] = keys[i+1];
								tags[i] = tags[i+1];
							end
							held--;
							queue_result(STS_OK, at, k, t, 1'b1);
						end
					end
				end
				OP_SEARCH: begin
					if (held == 0)
						queue_result(STS_EMPTY, 0, '0, '0, 1'b1);
					else begin
						hits = 0;
						for (i = 0; i < held && hits < MAX_RESULTS; i++) begin
							if (keys[i] == q.record_key) begin
								queue_result(STS_OK, i, keys[i], tags[i], 1'b0);
								hits++;
							end
						end
						if (hits == 0)
							queue_result(STS_NOTFOUND, 0, '0, '0, 1'b1);
						else begin
							// mark the final match
							r = awaited_rsps.pop_back();
							r.last = 1'b1;
							awaited_rsps.push_back(r);
							if (hits > 1)
								multi_hits++;
						end
					end
				end
				default: queue_result(STS_BADPOS, 0, '0, '0, 1'b1);
			endcase
		endfunction

		function void check_response(sle_rsp_t got);
			sle_rsp_t want;
			if (awaited_rsps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response: sts=%0d pos=%0d key=%h tag=%h cnt=%0d last=%0b",
						got.status, got.found_position, got.out_key, got.out_name_tag,
						got.entry_count, got.last);
				return;
			end
			want = awaited_rsps.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  expected sts=%0d pos=%0d key=%h tag=%h cnt=%0d last=%0b",
						want.status, want.found_position, want.out_key, want.out_name_tag,
						want.entry_count, want.last);
					$display("  actual   sts=%0d pos=%0d key=%h tag=%h cnt=%0d last=%0b",
						got.status, got.found_position, got.out_key, got.out_name_tag,
						got.entry_count, got.last);
				end
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	sle_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	sle_rsp_t rsp;

	bit calm_tail;
	bit sender_gaps;
	int ready_hold;
	int sent;
	list_scoreboard sb = new();

	sequential_list_engine #(
		.LIST_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Note transfers on both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	// Consumer: ready and stall in random bursts, always ready at the end
	initial begin
		rsp_ready = 1'b0;
		ready_hold = 0;
		forever begin
			@(negedge clk);
			if (calm_tail)
				rsp_ready <= 1'b1;
			else if (ready_hold > 0)
				ready_hold--;
			else if ($urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				ready_hold = $urandom_range(0, 15);
			end else begin
				rsp_ready <= 1'b1;
				ready_hold = $urandom_range(0, ($urandom_range(0, 4) == 0) ? 60 : 15);
			end
		end
	end

	function automatic sle_req_t make_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
		logic [TAG_W-1:0] t, logic [POS_W-1:0] pos);
		sle_req_t q;
		q.operation  = op;
		q.record_key = k;
		q.name_tag   = t;
		q.position   = pos;
		return q;
	endfunction

	// Mostly keys from a small pool so searches hit several positions
	function automatic sle_req_t random_request(int ins_pct);
		sle_req_t q;
		int r;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: q.record_key = KEY_W'($urandom_range(1, 6));
			6: q.record_key = KEY_MAX;
			7: q.record_key = '0;
			default: q.record_key = KEY_W'($urandom());
		endcase
		q.name_tag = $urandom();
		if ($urandom_range(0, 4) == 0)
			q.position = POS_W'($urandom_range(0, 31));
		else
			q.position = POS_W'($urandom_range(0, sb.held + 1));
		r = $urandom_range(0, 99);
		if (r < 3)
			q.operation = OP_UNDEFINED;
		else if (r < 22)
			q.operation = OP_SEARCH;
		else if ($urandom_range(0, 99) < ins_pct) begin
			case ($urandom_range(0, 3))
				0: q.operation = OP_INS_HEAD;
				1: q.operation = OP_INS_TAIL;
				default: q.operation = OP_INS_POS;
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0: q.operation = OP_REM_HEAD;
				1: q.operation = OP_REM_TAIL;
				default: q.operation = OP_REM_POS;
			endcase
		end
		return q;
	endfunction

	// Enter and leave at a falling edge
	task automatic send(sle_req_t item);
		if (!calm_tail && sender_gaps && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		while (sb.awaited_rsps.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(int n, int ins_pct);
		int i;
		for (i = 0; i < n; i++)
			send(random_request(ins_pct));
	endtask

	initial begin
		int i;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		calm_tail   = 1'b0;
		sender_gaps = 1'b1;
		sent        = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list, unknown operation, bad positions, extremes
		send(make_req(OP_REM_HEAD, '0, '0, '0));
		send(make_req(OP_SEARCH, '0, '0, '0));
		send(make_req(OP_UNDEFINED, KEY_MAX, TAG_MAX, '1));
		send(make_req(OP_INS_POS, 31'd9, 32'd9, 5'd1));
		send(make_req(OP_INS_HEAD, KEY_MAX, TAG_MAX, '1));
		send(make_req(OP_INS_POS, '0, '0, 5'd1));
		send(make_req(OP_REM_POS, '0, '0, 5'd2));
		send(make_req(OP_SEARCH, 31'd5, '0, '0));
		send(make_req(OP_REM_TAIL, '0, '0, '0));
		send(make_req(OP_REM_HEAD, '0, '0, '0));
		// fill with one key, overflow, then a search that matches every place
		for (i = 0; i < DEPTH; i++) begin
			case (i % 3)
				0: send(make_req(OP_INS_HEAD, FILL_KEY, $urandom(), '0));
				1: send(make_req(OP_INS_TAIL, FILL_KEY, $urandom(), '0));
				default: send(make_req(OP_INS_POS, FILL_KEY, $urandom(),
					POS_W'($urandom_range(0, sb.held))));
			endcase
		end
		send(make_req(OP_INS_TAIL, 31'd1, 32'd1, '0));
		send(make_req(OP_SEARCH, FILL_KEY, '0, '0));
		hold_until_drained();

		run_phase(100, 70);
		hold_until_drained();
		sender_gaps = 1'b0;
		run_phase(60, 30);
		sender_gaps = 1'b1;
		run_phase(60, 30);
		hold_until_drained();
		run_phase(110, 50);
		calm_tail = 1'b1;
		run_phase(50, 55);
		req_valid <= 1'b0;

		while (sb.awaited_rsps.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d requests, checked %0d responses, %0d searches with several hits",
			sent, sb.checked, sb.multi_hits);
		$display("flags seen: full %0d, empty %0d, bad position %0d, not found %0d",
			sb.flag_hits[STS_FULL], sb.flag_hits[STS_EMPTY], sb.flag_hits[STS_BADPOS],
			sb.flag_hits[STS_NOTFOUND]);
		if (sb.awaited_rsps.size() != 0)
			$display("%0d responses never arrived", sb.awaited_rsps.size());
		if (sb.errors == 0 && sb.awaited_rsps.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
